FILE: hdl/tbd_pkg.sv
// Shared types and constants for the three-button debounce and long-press core.
package tbd_pkg;

  localparam int TICK_W = 16;
  localparam int NBTN   = 3;
  localparam int NFLAG  = 5;

  // Button positions in the level vectors.
  localparam int BTN_RS  = 0;
  localparam int BTN_INC = 1;
  localparam int BTN_DEC = 2;

  // Flag positions.
  localparam int F_PRESS_RS  = 0;
  localparam int F_PRESS_INC = 1;
  localparam int F_PRESS_DEC = 2;
  localparam int F_LONG_INC  = 3;
  localparam int F_LONG_DEC  = 4;

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS   = 2'd0,
    CFG_RESET_REPEAT = 2'd1,
    CFG_PRESS_LEVEL  = 2'd2
  } cfg_idx_t;

  localparam logic [TICK_W-1:0] LONG_PRESS_RST   = 16'd300;
  localparam logic [TICK_W-1:0] RESET_REPEAT_RST = 16'd200;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic [4:0] clear_mask;
    logic       raw_dec;
    logic       raw_inc;
    logic       raw_reset;
  } in_item_t;

  typedef struct packed {
    logic [OUT_DATA_W-NFLAG-1:0] pad;
    logic                        long_dec;
    logic                        long_inc;
    logic                        press_dec;
    logic                        press_inc;
    logic                        press_reset;
  } out_item_t;

endpackage

FILE: hdl/three_button_debounce_long_press_core.sv
// Three-button debounce with shared hold timer and long-press / auto-repeat flags.
// Takes one sample request per clock cycle while the output is not stalled and returns
// its flag result in the next cycle through an output register; a new request is taken
// whenever that register is empty or being drained, so full rate is one request per cycle.
// The cycle is set by the hold timer update: up to four chained 16-bit
// decrement-and-zero-checks from the timer register back to itself.
module three_button_debounce_long_press_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // raw_reset, raw_inc, raw_dec, clear_mask[4:0]
  input  logic [tbd_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // press_reset, press_inc, press_dec, long_inc, long_dec, 3 zero bits
  output logic [tbd_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_we,
  input  logic [tbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbd_pkg::TICK_W-1:0]          cfg_data
);
  import tbd_pkg::*;

  logic [TICK_W-1:0] long_ticks_r;
  logic [TICK_W-1:0] repeat_ticks_r;
  logic              level_r;

  logic [NBTN-1:0]   hist_a_r, hist_a_nxt;
  logic [NBTN-1:0]   hist_b_r, hist_b_nxt;
  logic [NBTN-1:0]   stable_r, stable_nxt;
  logic [TICK_W-1:0] timer_r, timer_nxt;
  logic [NFLAG-1:0]  flags_r, flags_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;

  in_item_t          in_item;
  logic [NBTN-1:0]   raw;
  logic              accept;

  assign in_item   = in_tdata;
  assign raw       = {in_item.raw_dec, in_item.raw_inc, in_item.raw_reset};
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r   <= LONG_PRESS_RST;
      repeat_ticks_r <= RESET_REPEAT_RST;
      level_r        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_PRESS:   long_ticks_r   <= cfg_data;
        CFG_RESET_REPEAT: repeat_ticks_r <= cfg_data;
        CFG_PRESS_LEVEL:  level_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [NFLAG-1:0]  f;
    logic [NBTN-1:0]   s;
    logic [TICK_W-1:0] t;
    logic              agree;
    f = flags_r & ~in_item.clear_mask;
    s = stable_r;
    t = timer_r;
    agree = 1'b0;

    for (int b = BTN_INC; b <= BTN_DEC; b++) begin
      agree = (hist_a_r[b] == hist_b_r[b]) && (hist_b_r[b] == raw[b]);
      if (agree) begin
        if (s[b] != raw[b]) begin
          s[b] = raw[b];
          if (raw[b] == level_r) begin
            t = long_ticks_r;
            f[F_PRESS_INC] = f[F_PRESS_INC] | (s[BTN_INC] == level_r);
            f[F_PRESS_DEC] = f[F_PRESS_DEC] | (s[BTN_DEC] == level_r);
            f[F_PRESS_RS]  = f[F_PRESS_RS]  | (s[BTN_RS]  == level_r);
          end
        end else begin
          t = t - TICK_W'(1);
          if (t == '0) begin
            if (raw[b] == level_r) begin
              f[F_LONG_INC] = f[F_LONG_INC] | (s[BTN_INC] == level_r);
              f[F_LONG_DEC] = f[F_LONG_DEC] | (s[BTN_DEC] == level_r);
            end
            t = long_ticks_r;
          end
        end
      end
    end

    agree = (hist_a_r[BTN_RS] == hist_b_r[BTN_RS]) && (hist_b_r[BTN_RS] == raw[BTN_RS]);
    if (agree) begin
      if (s[BTN_RS] != raw[BTN_RS]) begin
        s[BTN_RS] = raw[BTN_RS];
        if (raw[BTN_RS] == level_r) begin
          t = repeat_ticks_r;
          f[F_PRESS_INC] = f[F_PRESS_INC] | (s[BTN_INC] == level_r);
          f[F_PRESS_DEC] = f[F_PRESS_DEC] | (s[BTN_DEC] == level_r);
          f[F_PRESS_RS]  = f[F_PRESS_RS]  | (s[BTN_RS]  == level_r);
        end
      end else begin
        t = t - TICK_W'(1);
        if (t == '0) begin
          s[BTN_RS] = ~level_r;
          t = repeat_ticks_r;
        end
      end
    end

    // all three held: one extra countdown step
    if ((s[BTN_INC] == level_r) && (s[BTN_DEC] == level_r) && (s[BTN_RS] == level_r)) begin
      t = t - TICK_W'(1);
      if (t == '0) begin
        s[BTN_RS] = ~level_r;
        t = repeat_ticks_r;
      end
    end

    hist_a_nxt = hist_b_r;
    hist_b_nxt = raw;
    stable_nxt = s;
    timer_nxt  = t;
    flags_nxt  = f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_a_r    <= '1;
      hist_b_r    <= '1;
      stable_r    <= '1;
      timer_r     <= LONG_PRESS_RST;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      hist_a_r    <= hist_a_nxt;
      hist_b_r    <= hist_b_nxt;
      stable_r    <= stable_nxt;
      timer_r     <= timer_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= '{pad: '0,
                      long_dec: flags_nxt[F_LONG_DEC],
                      long_inc: flags_nxt[F_LONG_INC],
                      press_dec: flags_nxt[F_PRESS_DEC],
                      press_inc: flags_nxt[F_PRESS_INC],
                      press_reset: flags_nxt[F_PRESS_RS]};
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(timer_r) && $stable(flags_r) && $stable(stable_r))
    else $error("debounce state changed without a request");

  a_result_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[NFLAG-1:0] == flags_r))
    else $error("result register out of step with flag state");

  a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result dropped or changed");

endmodule

FILE: dv/tb_three_button_debounce_long_press_core.sv
// Self-checking testbench: three-button debounce core, flag requests checked against a predictor.
module tb_three_button_debounce_long_press_core;
  import tbd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  // raw_reset, raw_inc, raw_dec, clear_mask[4:0]
  logic [IN_DATA_W-1:0]    in_tdata   = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  // press_reset, press_inc, press_dec, long_inc, long_dec, 3 zero bits
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [TICK_W-1:0]       cfg_data   = '0;

  three_button_debounce_long_press_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // debounce state; history bit 2 is the newest sample
  logic [2:0]        btn_hist [NBTN];
  logic [NBTN-1:0]   btn_level;
  logic [TICK_W-1:0] hold_cnt;
  logic [TICK_W-1:0] cfg_long;
  logic [TICK_W-1:0] cfg_repeat;
  logic              cfg_pressed;
  logic [NFLAG-1:0]  flag_reg;

  logic [NFLAG-1:0]  flags_due [$];
  logic [NFLAG-1:0]  flags_exp;
  string             flag_name [NFLAG] =
    '{"press_reset", "press_inc", "press_dec", "long_inc", "long_dec"};
  int                mismatch_cnt = 0;
  int                ready_wait   = 0;
  bit                no_idle      = 1'b0;

  function automatic void reset_model();
    cfg_long    = LONG_PRESS_RST;
    cfg_repeat  = RESET_REPEAT_RST;
    cfg_pressed = 1'b0;
    for (int b = 0; b < NBTN; b++) btn_hist[b] = 3'b111;
    btn_level = '1;
    hold_cnt  = LONG_PRESS_RST;
    flag_reg  = '0;
  endfunction

  function automatic bit is_down(int b);
    return btn_level[b] == cfg_pressed;
  endfunction

  function automatic bit settled(int b);
    return btn_hist[b] == 3'b000 || btn_hist[b] == 3'b111;
  endfunction

  function automatic bit count_to_zero();
    hold_cnt = hold_cnt - TICK_W'(1);
    return hold_cnt == '0;
  endfunction

  function automatic void mark_presses();
    if (is_down(BTN_INC)) flag_reg[F_PRESS_INC] = 1'b1;
    if (is_down(BTN_DEC)) flag_reg[F_PRESS_DEC] = 1'b1;
    if (is_down(BTN_RS))  flag_reg[F_PRESS_RS]  = 1'b1;
  endfunction

  function automatic void mark_long();
    if (is_down(BTN_INC)) flag_reg[F_LONG_INC] = 1'b1;
    if (is_down(BTN_DEC)) flag_reg[F_LONG_DEC] = 1'b1;
  endfunction

  // reset hold timeout: release the stable level so the button presses again
  function automatic void reset_repeat();
    btn_level[BTN_RS] = ~cfg_pressed;
    hold_cnt          = cfg_repeat;
  endfunction

  function automatic void step_updown(int b);
    logic now;
    if (!settled(b)) return;
    now = btn_hist[b][2];
    if (btn_level[b] != now) begin
      btn_level[b] = now;
      if (now == cfg_pressed) begin
        hold_cnt = cfg_long;
        mark_presses();
      end
    end else if (count_to_zero()) begin
      if (now == cfg_pressed) mark_long();
      hold_cnt = cfg_long;
    end
  endfunction

  function automatic logic [NFLAG-1:0] predict_flags(logic [NBTN-1:0] pins,
                                                     logic [NFLAG-1:0] clr);
    logic now;
    flag_reg &= ~clr;
    for (int b = 0; b < NBTN; b++) btn_hist[b] = {pins[b], btn_hist[b][2:1]};
    step_updown(BTN_INC);
    step_updown(BTN_DEC);
    if (settled(BTN_RS)) begin
      now = btn_hist[BTN_RS][2];
      if (btn_level[BTN_RS] != now) begin
        btn_level[BTN_RS] = now;
        if (now == cfg_pressed) begin
          hold_cnt = cfg_repeat;
          mark_presses();
        end
      end else if (count_to_zero()) begin
        reset_repeat();
      end
    end
    if (is_down(BTN_INC) && is_down(BTN_DEC) && is_down(BTN_RS)) begin
      if (count_to_zero()) reset_repeat();
    end
    return flag_reg;
  endfunction

  function automatic logic [NFLAG-1:0] rand_clear();
    if ($urandom_range(0, 3) == 0) return NFLAG'($urandom_range(0, 31));
    return '0;
  endfunction

  task automatic send_item(logic [NBTN-1:0] pins, logic [NFLAG-1:0] clr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {clr, pins};
    do @(posedge clk); while (!in_tready);
    flags_due.push_back(predict_flags(pins, clr));
  endtask

  // down: one bit per button that is held; pin level follows cfg_pressed
  task automatic press(logic [NBTN-1:0] down, int n, logic [NFLAG-1:0] clr);
    repeat (n) send_item(cfg_pressed ? down : ~down, clr);
  endtask

  task automatic quiesce();
    @(negedge clk) in_tvalid <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
    quiesce();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      CFG_LONG_PRESS:   cfg_long    = val;
      CFG_RESET_REPEAT: cfg_repeat  = val;
      CFG_PRESS_LEVEL:  cfg_pressed = val[0];
      default: ;
    endcase
  endtask

  task automatic test_idle_after_reset();
    press(3'b000, 2, 5'b11111);
    press(3'b000, 1, 5'b00000);
  endtask

  task automatic test_press_and_clear();
    press(3'b010, 2, '0);   // too short to settle
    press(3'b000, 1, '0);
    press(3'b010, 3, '0);
    press(3'b000, 3, '0);
    press(3'b000, 1, 5'b00010);
  endtask

  task automatic test_long_press_repeat();
    write_reg(CFG_LONG_PRESS, 16'd2);
    write_reg(CFG_RESET_REPEAT, 16'd1);
    press(3'b111, 6, '0);   // all three held: extra countdown and auto-repeat
    press(3'b000, 3, '0);
    press(3'b000, 1, 5'b11111);
  endtask

  task automatic test_zero_reload_level_swap();
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    write_reg(CFG_LONG_PRESS, 16'd0);
    write_reg(CFG_RESET_REPEAT, 16'd0);
    write_reg(CFG_PRESS_LEVEL, 16'd1);  // stored levels now read as pressed
    press(3'b001, 4, 5'b11111);
  endtask

  task automatic random_traffic(int n);
    int sent;
    int len;
    logic [NBTN-1:0] down;
    sent = 0;
    while (sent < n) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 4);
        repeat (len) send_item(NBTN'($urandom_range(0, 7)), rand_clear());
      end else begin
        down = NBTN'($urandom_range(0, 7));
        len  = $urandom_range(3, 16);
        if ($urandom_range(0, 7) == 0) len = $urandom_range(17, 40);
        repeat (len) press(down, 1, rand_clear());
      end
      sent += len;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_holds();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_LONG_PRESS, 16'd1);
          write_reg(CFG_RESET_REPEAT, 16'd1);
          write_reg(CFG_PRESS_LEVEL, 16'd0);
        end
        1: begin
          write_reg(CFG_LONG_PRESS, 16'hFFFF);
          write_reg(CFG_RESET_REPEAT, 16'hFFFF);
          write_reg(CFG_PRESS_LEVEL, 16'd1);
        end
        2: begin
          write_reg(CFG_LONG_PRESS, TICK_W'($urandom_range(2, 12)));
          write_reg(CFG_RESET_REPEAT, TICK_W'($urandom_range(2, 12)));
          write_reg(CFG_PRESS_LEVEL, TICK_W'($urandom_range(0, 1)));
        end
        default: begin
          write_reg(CFG_LONG_PRESS, LONG_PRESS_RST);
          write_reg(CFG_RESET_REPEAT, RESET_REPEAT_RST);
          write_reg(CFG_PRESS_LEVEL, 16'd0);
          press(3'b110, 310, '0);
          press(3'b000, 3, 5'b11111);
        end
      endcase
      random_traffic((phase == 3) ? 40 : 70);
    end
  endtask

  always @(negedge clk) begin
    if (ready_wait > 0) begin
      out_tready <= 1'b0;
      ready_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      ready_wait = no_idle ? 0 : $urandom_range(0, 5);
      if (flags_due.size() == 0) begin
        $display("%0t: unexpected request result, expected none, got %b", $time, out_tdata);
        mismatch_cnt++;
      end else begin
        flags_exp = flags_due.pop_front();
        for (int f = 0; f < NFLAG; f++) begin
          if (out_tdata[f] !== flags_exp[f]) begin
            $display("%0t: %s expected %b got %b", $time, flag_name[f], flags_exp[f],
                     out_tdata[f]);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_idle_after_reset();
    test_press_and_clear();
    test_long_press_repeat();
    test_zero_reload_level_swap();
    test_random_holds();
    quiesce();
    repeat (5) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hdl/tbd_pkg.sv
hdl/three_button_debounce_long_press_core.sv
dv/tb_three_button_debounce_long_press_core.sv
